@@ sv/pqnce_pkg.sv @@
// Package for the product-quantization nearest-centroid encoder.
// Holds parameter defaults, port widths, request codes and the sequencer state type.
// No dependencies.
package pqnce_pkg;

    localparam int MAX_SUBSPACES_DEF = 16;
    localparam int MAX_CENTROIDS_DEF = 256;
    localparam int LANES_DEF         = 8;
    localparam int VALUE_BITS_DEF    = 16;

    localparam int ELEM_W      = 16;
    localparam int SUBSPACE_W  = 4;
    localparam int CENTROID_W  = 8;
    localparam int CODE_W      = 8;
    localparam int NUM_ELEMS   = 8;
    localparam int S_TDATA_W   = 144;
    localparam int M_TDATA_W   = 16;
    localparam int ELEM_LSB    = SUBSPACE_W + CENTROID_W;

    localparam int NC_W        = 9;
    localparam int DIM_W       = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;

    localparam logic [NC_W-1:0]  NUM_CENTROIDS_RST = 9'd256;
    localparam logic [DIM_W-1:0] SUBSPACE_DIM_RST  = 4'd8;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_CENTROIDS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUBSPACE_DIM  = 1'b1;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_ENCODE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

@@ sv/pq_nearest_centroid_encoder.sv @@
// Top level of the product-quantization nearest-centroid encoder.
// Holds the codebook memory, the scan sequencer and the shared distance datapath.
// Depends on pqnce_pkg.
//
// A request with tuser low writes one codebook row and gives no result.
// A request with tuser high encodes a subvector: the sequencer reads one codebook
// row per cycle from the single memory read port and feeds it through a shared
// pipeline (difference and square on all lanes, lane sum, strict compare), so an
// encode holds the input side low until its result is loaded into the output
// register, so no new request is taken during the scan; an out-of-range subspace
// skips the scan and returns code 0. The result sits in an output register, and
// the next request is taken while it waits; an encode that finishes while that
// result still waits holds in the done state. Codebook rows hold undefined data
// until written; no clearing pass runs after reset.
module pq_nearest_centroid_encoder #(
    parameter int MAX_SUBSPACES = pqnce_pkg::MAX_SUBSPACES_DEF,
    parameter int MAX_CENTROIDS = pqnce_pkg::MAX_CENTROIDS_DEF,
    parameter int LANES         = pqnce_pkg::LANES_DEF,
    parameter int VALUE_BITS    = pqnce_pkg::VALUE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // subspace[3:0], centroid[11:4], elem0[27:12] .. elem7[139:124], zero pad
    input  logic [pqnce_pkg::S_TDATA_W-1:0]      s_tdata,
    // kind
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // subspace_out[3:0], code[11:4], zero pad
    output logic [pqnce_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pqnce_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pqnce_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int V       = VALUE_BITS;
    localparam int EXT_W   = (V > pqnce_pkg::ELEM_W) ? V : pqnce_pkg::ELEM_W;
    localparam int SUB_W   = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1;
    localparam int SUBX_W  = (SUB_W > pqnce_pkg::SUBSPACE_W) ? SUB_W : pqnce_pkg::SUBSPACE_W;
    localparam int CIDX_W  = $clog2(MAX_CENTROIDS);
    localparam int CNT_W   = $clog2(MAX_CENTROIDS + 1);
    localparam int ADDR_W  = SUB_W + CIDX_W;
    localparam int DEPTH   = MAX_SUBSPACES << CIDX_W;
    localparam int ROW_W   = LANES * V;
    localparam int SQ_W    = 2 * V + 1;
    localparam int SUM_W   = SQ_W + $clog2(LANES + 1);
    localparam int NC_W    = pqnce_pkg::NC_W;
    localparam int DIM_W   = pqnce_pkg::DIM_W;

    localparam logic [NC_W-1:0]  MAXC_NC   = NC_W'(MAX_CENTROIDS);
    localparam logic [DIM_W-1:0] LANES_DIM = DIM_W'(LANES);
    localparam logic [6:0]       MAXS_7    = 7'(MAX_SUBSPACES);

    pqnce_pkg::state_t state_reg, state_next;

    logic [NC_W-1:0]   num_centroids_reg;
    logic [DIM_W-1:0]  subspace_dim_reg;

    logic [ROW_W-1:0]  mem [DEPTH];
    logic [ROW_W-1:0]  rdata_reg;

    logic [ROW_W-1:0]  in_row;
    logic [ROW_W-1:0]  vec_reg;
    logic [pqnce_pkg::SUBSPACE_W-1:0] in_sub;
    logic [pqnce_pkg::CENTROID_W-1:0] in_row_idx;
    logic [SUBX_W-1:0] in_sub_x;
    logic [SUB_W-1:0]  in_sub_a;
    logic              in_sub_ok;
    logic              in_row_ok;
    logic              accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic [pqnce_pkg::SUBSPACE_W-1:0] sub_reg;
    logic [SUB_W-1:0]  sub_addr_reg;

    logic [NC_W-1:0]   k_nc;
    logic [CNT_W-1:0]  k_eff;
    logic [DIM_W-1:0]  dim_eff;

    logic [CNT_W-1:0]  issue_cnt_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic              v1_reg, v2_reg, v3_reg;
    logic [CIDX_W-1:0] idx1_reg, idx2_reg, idx3_reg;

    logic signed [V:0] diff   [LANES];
    logic [V:0]        mag    [LANES];
    logic [2*V+1:0]    prod   [LANES];
    logic [SQ_W-1:0]   sq_reg [LANES];
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_reg;

    logic [SUM_W-1:0]  best_dist_reg;
    logic [CIDX_W-1:0] best_idx_reg;
    logic              last_row;

    logic              m_tvalid_reg;
    logic [pqnce_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic              load_out;
    logic              scan_start;

    // Input unpacking
    always_comb
    begin
        logic [EXT_W-1:0] ext;
        in_row = '0;
        for (int l = 0; l < LANES; l++)
        begin
            ext = EXT_W'(s_tdata[pqnce_pkg::ELEM_LSB + pqnce_pkg::ELEM_W*l +: pqnce_pkg::ELEM_W]);
            in_row[l*V +: V] = ext[V-1:0];
        end
    end

    assign in_sub     = s_tdata[pqnce_pkg::SUBSPACE_W-1:0];
    assign in_row_idx = s_tdata[pqnce_pkg::ELEM_LSB-1:pqnce_pkg::SUBSPACE_W];
    assign in_sub_x   = SUBX_W'(in_sub);
    assign in_sub_a   = in_sub_x[SUB_W-1:0];
    assign in_sub_ok  = {3'b000, in_sub} < MAXS_7;
    assign in_row_ok  = {1'b0, in_row_idx} < MAXC_NC;
    assign accept     = s_tvalid && s_tready;
    assign wr_en      = accept && (s_tuser == pqnce_pkg::KIND_WRITE) && in_sub_ok && in_row_ok;
    assign wr_addr    = {in_sub_a, in_row_idx[CIDX_W-1:0]};
    assign scan_start = accept && (s_tuser == pqnce_pkg::KIND_ENCODE);

    // Effective configuration
    always_comb
    begin
        if (num_centroids_reg == '0)
            k_nc = NC_W'(1);
        else if (num_centroids_reg > MAXC_NC)
            k_nc = MAXC_NC;
        else
            k_nc = num_centroids_reg;
        k_eff = k_nc[CNT_W-1:0];
        dim_eff = (subspace_dim_reg > LANES_DIM) ? LANES_DIM : subspace_dim_reg;
    end

    assign rd_addr  = {sub_addr_reg, issue_cnt_reg[CIDX_W-1:0]};
    assign last_row = v3_reg && ({1'b0, idx3_reg} == CNT_W'(k_eff - CNT_W'(1)));

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_centroids_reg <= pqnce_pkg::NUM_CENTROIDS_RST;
            subspace_dim_reg  <= pqnce_pkg::SUBSPACE_DIM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pqnce_pkg::CFG_NUM_CENTROIDS: num_centroids_reg <= cfg_data[NC_W-1:0];
                pqnce_pkg::CFG_SUBSPACE_DIM:  subspace_dim_reg  <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Codebook memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= in_row;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pqnce_pkg::ST_IDLE:
            begin
                if (scan_start)
                    state_next = in_sub_ok ? pqnce_pkg::ST_SCAN : pqnce_pkg::ST_DONE;
            end
            pqnce_pkg::ST_SCAN:
            begin
                if (last_row)
                    state_next = pqnce_pkg::ST_DONE;
            end
            pqnce_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = pqnce_pkg::ST_IDLE;
            end
            default: state_next = pqnce_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            pqnce_pkg::ST_IDLE: s_tready = 1'b1;
            pqnce_pkg::ST_SCAN: rd_en    = issue_cnt_reg < k_eff;
            pqnce_pkg::ST_DONE: load_out = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pqnce_pkg::ST_IDLE;
            issue_cnt_reg <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (scan_start)
                issue_cnt_reg <= '0;
            else if (rd_en)
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Difference and square on all lanes
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            diff[l] = $signed({vec_reg[l*V + V - 1], vec_reg[l*V +: V]})
                    - $signed({rdata_reg[l*V + V - 1], rdata_reg[l*V +: V]});
            mag[l]  = diff[l][V] ? (V+1)'(-diff[l]) : (V+1)'(diff[l]);
            prod[l] = mag[l] * mag[l];
        end
    end

    // Lane sum
    always_comb
    begin
        sum_next = '0;
        for (int l = 0; l < LANES; l++)
            sum_next = sum_next + SUM_W'(sq_reg[l]);
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (scan_start)
        begin
            vec_reg      <= in_row;
            sub_reg      <= in_sub;
            sub_addr_reg <= in_sub_a;
        end
        idx1_reg <= issue_cnt_reg[CIDX_W-1:0];
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        for (int l = 0; l < LANES; l++)
            sq_reg[l] <= (DIM_W'(l) < dim_eff) ? prod[l][SQ_W-1:0] : '0;
        sum_reg <= sum_next;
        if (v3_reg && ((idx3_reg == '0) || (sum_reg < best_dist_reg)))
            best_dist_reg <= sum_reg;
        if (load_out)
            m_tdata_reg <= {4'b0000, pqnce_pkg::CODE_W'(best_idx_reg), sub_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            best_idx_reg <= '0;
        else if (scan_start)
            best_idx_reg <= '0;
        else if (v3_reg && ((idx3_reg == '0) || (sum_reg < best_dist_reg)))
            best_idx_reg <= idx3_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg || v2_reg || v3_reg) |-> (state_reg == pqnce_pkg::ST_SCAN))
        else $error("scan pipeline busy outside scan");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pqnce_pkg::ST_SCAN) |-> (issue_cnt_reg <= k_eff))
        else $error("row issue count beyond centroid count");

    a_code_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pqnce_pkg::ST_DONE) |-> ({1'b0, best_idx_reg} < k_eff))
        else $error("best row outside searched range");

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == pqnce_pkg::ST_SCAN) && (state_next == pqnce_pkg::ST_DONE))
        |-> !rd_en)
        else $error("scan finished with rows still to issue");
`endif

endmodule
